// ===== src/mot_pkg.sv =====
package mot_pkg;

    localparam int MAG_W = 32;
    localparam int LOG_W = 21;
    localparam int OUT_W = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS = 16;
    localparam int DIV_DEN_W = 40;
    localparam int DIV_REM_W = 41;

    localparam logic [OUT_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [17:0] LOG2_TEN_Q16 = 18'd217705;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MINPOS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECADES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY = 3'd4;

    typedef enum logic [1:0] {
        KIND_DIV  = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_ONE  = 2'd2,
        KIND_DEC  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [4:0]  e;
        logic [31:0] m;
    } lz_t;

    function automatic lz_t leading_one(input logic [MAG_W-1:0] x);
        lz_t r;
        r.e = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (x[i]) r.e = i[4:0];
        end
        r.m = x << (5'd31 - r.e);
        return r;
    endfunction

    function automatic logic [32:0] sq_step(input logic [31:0] m);
        logic [63:0] p;
        p = 64'(m) * 64'(m);
        return p[63:31];
    endfunction

endpackage

// ===== src/magnitude_opacity_transfer.sv =====
// magnitude to normalized value and opacity, fully pipelined
// channels: start/magnitude in (accepted when start is high and busy low;
// busy is tied low), done/normalized/opacity out. done is high for exactly
// one cycle per item and the receiver cannot stall, so nothing holds back.
// throughput: one item per clock, back to back.
// stages: stage 0 registers the sample, the next stage registers the leading
// ones, 16 squaring stages form log2 fractions, one stage subtracts logs and
// forms divider operands, 4 radix-16 divider stages (4 quotient bits each),
// one stage subtracts from one, one stage multiplies by density scale and
// saturates.
// configuration: cfg_we/cfg_index/cfg_data write a register when cfg_we is high;
// only change it while no item is in flight. reset clears all valid bits
// and loads register reset values (density scale 1.0, others zero).
module magnitude_opacity_transfer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [mot_pkg::MAG_W-1:0]        magnitude,
    output logic                             done,
    output logic [mot_pkg::OUT_W-1:0]        normalized,
    output logic [mot_pkg::OUT_W-1:0]        opacity,
    input  logic                             cfg_we,
    input  logic [mot_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mot_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NS = 16;
    localparam int DW = mot_pkg::DIV_DEN_W;
    localparam int RW = mot_pkg::DIV_REM_W;
    localparam int DS = 4;

    logic                     mode_reg;
    logic [31:0]              max_reg;
    logic [31:0]              minpos_reg;
    logic [15:0]              dec_reg;
    logic [15:0]              dens_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg   <= 1'b0;
            max_reg    <= '0;
            minpos_reg <= '0;
            dec_reg    <= '0;
            dens_reg   <= 16'd256;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mot_pkg::REG_MODE:    mode_reg   <= cfg_data[0];
                mot_pkg::REG_MAX:     max_reg    <= cfg_data;
                mot_pkg::REG_MINPOS:  minpos_reg <= cfg_data;
                mot_pkg::REG_DECADES: dec_reg    <= cfg_data[15:0];
                mot_pkg::REG_DENSITY: dens_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 0: sample capture and leading one for three log operands
    logic        v0_reg;
    logic [31:0] m0_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) v0_reg <= 1'b0;
        else        v0_reg <= start;
    end
    always_ff @(posedge clk) begin
        m0_reg <= magnitude;
    end

    logic [31:0] minp_eff;
    assign minp_eff = (minpos_reg == '0) ? 32'd1 : minpos_reg;

    mot_pkg::lz_t lz_m, lz_x, lz_p;
    assign lz_m = mot_pkg::leading_one(m0_reg);
    assign lz_x = mot_pkg::leading_one(max_reg);
    assign lz_p = mot_pkg::leading_one(minp_eff);

    // log pipeline: per lane mantissa and accumulated fraction
    logic [NS:0]       lv_reg;
    logic [31:0]       lm_reg  [3][NS+1];
    logic [15:0]       lf_reg  [3][NS+1];
    logic [4:0]        le_reg  [3][NS+1];
    logic [31:0]       sm_reg  [NS+1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) lv_reg <= '0;
        else        lv_reg <= {lv_reg[NS-1:0], v0_reg};
    end

    always_ff @(posedge clk) begin
        lm_reg[0][0] <= lz_m.m;
        lm_reg[1][0] <= lz_x.m;
        lm_reg[2][0] <= lz_p.m;
        le_reg[0][0] <= lz_m.e;
        le_reg[1][0] <= lz_x.e;
        le_reg[2][0] <= lz_p.e;
        lf_reg[0][0] <= '0;
        lf_reg[1][0] <= '0;
        lf_reg[2][0] <= '0;
        sm_reg[0]    <= m0_reg;
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        for (genvar s = 0; s < NS; s++) begin : g_sq
            logic [32:0] sq;
            assign sq = mot_pkg::sq_step(lm_reg[l][s]);
            always_ff @(posedge clk) begin
                lm_reg[l][s+1] <= sq[32] ? sq[32:1] : sq[31:0];
                lf_reg[l][s+1] <= {lf_reg[l][s][14:0], sq[32]};
                le_reg[l][s+1] <= le_reg[l][s];
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_smag
        always_ff @(posedge clk) begin
            sm_reg[s+1] <= sm_reg[s];
        end
    end

    logic [mot_pkg::LOG_W-1:0] log_m, log_x, log_p;
    assign log_m = {le_reg[0][NS], lf_reg[0][NS]};
    assign log_x = {le_reg[1][NS], lf_reg[1][NS]};
    assign log_p = {le_reg[2][NS], lf_reg[2][NS]};

    // operand stage: pick case and divider operands
    logic [31:0] mag_l;
    assign mag_l = sm_reg[NS];

    mot_pkg::kind_t kind_c;
    logic [DW-1:0]  num_c, den_c;
    logic [33:0]    dprod;
    assign dprod = 34'(dec_reg) * 34'(mot_pkg::LOG2_TEN_Q16);

    always_comb begin
        kind_c = mot_pkg::KIND_ZERO;
        num_c  = '0;
        den_c  = DW'(1);
        if (!mode_reg) begin
            if (max_reg == '0) kind_c = mot_pkg::KIND_ZERO;
            else if (mag_l >= max_reg) kind_c = mot_pkg::KIND_ONE;
            else begin
                kind_c = mot_pkg::KIND_DIV;
                num_c  = DW'(mag_l);
                den_c  = DW'(max_reg);
            end
        end else if (dec_reg != '0) begin
            if (mag_l == '0 || max_reg == '0) kind_c = mot_pkg::KIND_ZERO;
            else if (log_m >= log_x) kind_c = mot_pkg::KIND_ONE;
            else begin
                // q = ((lx-lm)<<24)/(D*k); dividing (lx-lm)<<8 by D*k gives
                // integer part (must be 0 else q>=65536) then 16 fraction bits
                kind_c = mot_pkg::KIND_DEC;
                num_c  = DW'({log_x - log_m, 8'd0});
                den_c  = DW'(dprod);
            end
        end else begin
            if (mag_l > minpos_reg && max_reg > minpos_reg) begin
                if ((log_m - log_p) >= (log_x - log_p)) kind_c = mot_pkg::KIND_ONE;
                else begin
                    kind_c = mot_pkg::KIND_DIV;
                    num_c  = DW'(log_m - log_p);
                    den_c  = DW'(log_x - log_p);
                end
            end
        end
    end

    // in decade mode the quotient overflows when num >= den
    logic ovf_c;
    assign ovf_c = num_c >= den_c;

    logic           vd_reg [DS+1];
    mot_pkg::kind_t kd_reg [DS+1];
    logic           od_reg [DS+1];
    logic [RW-1:0]  rd_reg [DS+1];
    logic [DW-1:0]  dd_reg [DS+1];
    logic [15:0]    qd_reg [DS+1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) vd_reg[0] <= 1'b0;
        else        vd_reg[0] <= lv_reg[NS];
    end
    always_ff @(posedge clk) begin
        kd_reg[0] <= kind_c;
        od_reg[0] <= ovf_c;
        rd_reg[0] <= ovf_c ? '0 : RW'(num_c);
        dd_reg[0] <= den_c;
        qd_reg[0] <= '0;
    end

    // restoring divider, four quotient bits per stage
    for (genvar s = 0; s < DS; s++) begin : g_div
        logic [RW-1:0] r_n;
        logic [15:0]   q_n;
        always_comb begin
            r_n = rd_reg[s];
            q_n = qd_reg[s];
            for (int b = 0; b < 4; b++) begin
                r_n = {r_n[RW-2:0], 1'b0};
                q_n = {q_n[14:0], 1'b0};
                if (r_n >= RW'(dd_reg[s])) begin
                    r_n   = r_n - RW'(dd_reg[s]);
                    q_n[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) vd_reg[s+1] <= 1'b0;
            else        vd_reg[s+1] <= vd_reg[s];
        end
        always_ff @(posedge clk) begin
            kd_reg[s+1] <= kd_reg[s];
            od_reg[s+1] <= od_reg[s];
            rd_reg[s+1] <= r_n;
            dd_reg[s+1] <= dd_reg[s];
            qd_reg[s+1] <= q_n;
        end
    end

    // result select
    logic                      vn_reg;
    logic [mot_pkg::OUT_W-1:0] n_reg;
    logic [mot_pkg::OUT_W-1:0] n_c;
    always_comb begin
        case (kd_reg[DS])
            mot_pkg::KIND_ZERO: n_c = '0;
            mot_pkg::KIND_ONE:  n_c = mot_pkg::ONE_Q16;
            mot_pkg::KIND_DEC:
                n_c = (od_reg[DS] || qd_reg[DS] == '0) ?
                      (od_reg[DS] ? '0 : mot_pkg::ONE_Q16) :
                      mot_pkg::ONE_Q16 - mot_pkg::OUT_W'(qd_reg[DS]);
            default:            n_c = mot_pkg::OUT_W'(qd_reg[DS]);
        endcase
    end
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) vn_reg <= 1'b0;
        else        vn_reg <= vd_reg[DS];
    end
    always_ff @(posedge clk) begin
        n_reg <= n_c;
    end

    // opacity: scale and saturate
    logic [32:0] prod;
    logic [24:0] scaled;
    assign prod   = 33'(n_reg) * 33'(dens_reg);
    assign scaled = prod[32:8];

    logic                      done_reg;
    logic [mot_pkg::OUT_W-1:0] norm_reg;
    logic [mot_pkg::OUT_W-1:0] opac_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= vn_reg;
    end
    always_ff @(posedge clk) begin
        norm_reg <= n_reg;
        opac_reg <= (scaled > 25'(mot_pkg::ONE_Q16)) ? mot_pkg::ONE_Q16 :
                    scaled[mot_pkg::OUT_W-1:0];
    end

    assign done       = done_reg;
    assign normalized = norm_reg;
    assign opacity    = opac_reg;

endmodule

// ===== sim/tb_magnitude_opacity_transfer.sv =====
module tb_magnitude_opacity_transfer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mot_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [mot_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int PIPE_LAT = 24;
    localparam int STALL_LIMIT = 4000;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_BEATS = 100;

    class opacity_scoreboard;
        bit        log_mode;
        bit [31:0] mag_max;
        bit [31:0] mag_min_pos;
        bit [15:0] decades;
        bit [15:0] density;
        bit [mot_pkg::OUT_W-1:0] norm_q[$];
        bit [mot_pkg::OUT_W-1:0] opac_q[$];
        int errors;

        function new();
            log_mode = 1'b0;
            mag_max = '0;
            mag_min_pos = '0;
            decades = '0;
            density = 16'd256;
            errors = 0;
        endfunction

        function void write_reg(logic [mot_pkg::CFG_IDX_W-1:0] idx,
                                logic [mot_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mot_pkg::REG_MODE:    log_mode = data[0];
                mot_pkg::REG_MAX:     mag_max = data;
                mot_pkg::REG_MINPOS:  mag_min_pos = data;
                mot_pkg::REG_DECADES: decades = data[15:0];
                mot_pkg::REG_DENSITY: density = data[15:0];
                default: ;
            endcase
        endfunction

        // log2 of a raw integer as Q.16, fraction by repeated squaring
        function bit [63:0] log2_fix(bit [63:0] x);
            bit [63:0] ex;
            bit [63:0] mant;
            bit [63:0] frac;
            ex = 0;
            frac = 0;
            if (x == 0)
                return 0;
            while (ex < 63 && (x >> (ex + 1)) != 0)
                ex++;
            mant = (ex >= 31) ? (x >> (ex - 31)) : (x << (31 - ex));
            mant &= 64'hFFFF_FFFF;
            for (int i = 0; i < 16; i++)
            begin
                mant = (mant * mant) >> 31;
                frac = frac << 1;
                if (mant >= 64'h1_0000_0000)
                begin
                    frac |= 1;
                    mant >>= 1;
                end
            end
            return (ex << 16) | frac;
        endfunction

        function bit [63:0] normalize(bit [63:0] m);
            bit [63:0] lm, lx, lp, q, num, den;
            if (!log_mode)
            begin
                if (mag_max == 0) return 0;
                if (m >= mag_max) return 64'd65536;
                return (m << 16) / mag_max;
            end
            if (decades != 0)
            begin
                if (m == 0 || mag_max == 0) return 0;
                lm = log2_fix(m);
                lx = log2_fix(mag_max);
                if (lm >= lx) return 64'd65536;
                q = ((lx - lm) << 24) / (64'(decades) * 64'd217705);
                return (q >= 64'd65536) ? 0 : 64'd65536 - q;
            end
            if (m > mag_min_pos && mag_max > mag_min_pos)
            begin
                lp = log2_fix(mag_min_pos == 0 ? 64'd1 : 64'(mag_min_pos));
                num = log2_fix(m) - lp;
                den = log2_fix(mag_max) - lp;
                if (num >= den) return 64'd65536;
                return (num << 16) / den;
            end
            return 0;
        endfunction

        function void note_sample(bit [mot_pkg::MAG_W-1:0] m);
            bit [63:0] v, a;
            v = normalize(64'(m));
            a = (v * density) >> 8;
            if (a > 64'd65536) a = 64'd65536;
            norm_q.push_back(v[mot_pkg::OUT_W-1:0]);
            opac_q.push_back(a[mot_pkg::OUT_W-1:0]);
        endfunction

        function void check_result(logic [mot_pkg::OUT_W-1:0] n,
                                   logic [mot_pkg::OUT_W-1:0] o);
            bit [mot_pkg::OUT_W-1:0] en, eo;
            if (norm_q.size() == 0)
            begin
                $error("unexpected result normalized=%0d opacity=%0d", n, o);
                errors++;
                return;
            end
            en = norm_q.pop_front();
            eo = opac_q.pop_front();
            if (n !== en)
            begin
                $error("normalized: expected %0d actual %0d", en, n);
                errors++;
            end
            if (o !== eo)
            begin
                $error("opacity: expected %0d actual %0d", eo, o);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [mot_pkg::MAG_W-1:0] magnitude;
    logic done;
    logic [mot_pkg::OUT_W-1:0] normalized;
    logic [mot_pkg::OUT_W-1:0] opacity;
    logic cfg_we;
    logic [mot_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mot_pkg::CFG_DATA_W-1:0] cfg_data;

    opacity_scoreboard sb = new();
    int idle_pct;
    int stall_cycles = 0;

    magnitude_opacity_transfer u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .magnitude(magnitude),
        .done(done),
        .normalized(normalized),
        .opacity(opacity),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_sample(magnitude);
            if (done)
                sb.check_result(normalized, opacity);
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [mot_pkg::CFG_IDX_W-1:0] idx,
                             logic [mot_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_beat(logic [mot_pkg::MAG_W-1:0] m);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        magnitude <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.norm_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 6) @(posedge clk);
    endtask

    function automatic logic [mot_pkg::MAG_W-1:0] pick_magnitude();
        logic [mot_pkg::MAG_W-1:0] mx, mp;
        mx = sb.mag_max;
        mp = sb.mag_min_pos;
        case ($urandom_range(7))
            0: return $urandom;
            1: return mx + $urandom_range(4) - 2;
            2: return mp + $urandom_range(4) - 2;
            3: return 32'd1 << $urandom_range(31);
            4: return $urandom_range(255);
            5: return mx >> $urandom_range(31);
            6: return $urandom_range(mx > mp ? mx : mp, mp);
            default: return ~32'd0 - $urandom_range(3);
        endcase
    endfunction

    task automatic setup_phase(int ph);
        logic        md;
        logic [31:0] mx, mp;
        logic [15:0] dc, dn;
        md = 1'($urandom_range(1));
        mx = $urandom >> $urandom_range(24);
        mp = mx >> $urandom_range(20);
        dc = 16'($urandom_range(2047));
        dn = 16'($urandom_range(1023));
        case (ph)
            1: begin md = 1'b0; mx = 32'h0001_0000; dn = 16'd256; end
            2: begin md = 1'b1; mx = 32'h0100_0000; dc = 16'h0100; end
            3: begin md = 1'b1; mx = ~32'd0; mp = '0; dc = 16'd0; dn = 16'hFFFF; end
            4: begin md = 1'b1; mx = 32'h0001_0000; mp = 32'h100; dc = 16'd0; dn = 16'd0; end
            5: begin md = 1'b1; mp = mx + $urandom_range(3); dc = 16'd0; end
            6: begin md = 1'b1; dc = 16'hFFFF; end
            7: begin md = 1'b1; dc = 16'd1; mx = ~32'd0; end
            8: begin md = 1'b0; mx = 32'd1; dn = 16'hFFFF; end
            default: ;
        endcase
        // upper data bits must be ignored by the narrow registers
        write_reg(mot_pkg::REG_MODE, {31'($urandom), md});
        write_reg(mot_pkg::REG_MAX, mx);
        write_reg(mot_pkg::REG_MINPOS, mp);
        write_reg(mot_pkg::REG_DECADES, {16'($urandom_range(65535)), dc});
        write_reg(mot_pkg::REG_DENSITY, {16'($urandom_range(65535)), dn});
        write_reg(mot_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                  $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        magnitude = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: linear mode with zero max
        send_beat(32'd0);
        send_beat(~32'd0);
        send_beat(32'h8000_0000);
        drain();

        for (int ph = 1; ph < NUM_PHASES; ph++)
        begin
            setup_phase(ph);
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 46;
                2: idle_pct = 0;
                default: idle_pct = 29;
            endcase
            if (ph <= 3)
            begin
                send_beat(32'd0);
                send_beat(32'd1);
                send_beat(sb.mag_max);
                send_beat(sb.mag_max - 1);
                send_beat(sb.mag_max + 1);
                send_beat(sb.mag_min_pos + 1);
                send_beat(~32'd0);
            end
            for (int i = 0; i < PHASE_BEATS; i++)
                send_beat(pick_magnitude());
            drain();
        end

        if (sb.errors == 0 && sb.norm_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
